FILE: hw/rtl/pcx_rle_pkg.sv
// shared constants and widths for the pcx run-length row decoder
package pcx_rle_pkg;

    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 6;
    localparam int LINE_W  = 15;
    localparam int ROW_W   = 16;

    localparam logic [BYTE_W-1:0]  CODE_MASK  = 8'hC0;
    localparam logic [BYTE_W-1:0]  COUNT_MASK = 8'h3F;
    localparam logic [LINE_W-1:0]  LINE_RESET = 15'd320;

    // state codes of the run sequencer
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    typedef logic [BYTE_W-1:0]        byte_t;
    typedef logic [COUNT_W-1:0]       count_t;
    typedef logic [LINE_W-1:0]        line_t;
    typedef logic signed [ROW_W-1:0]  row_t;

endpackage

FILE: hw/rtl/pcx_rle_row_decoder.sv
// pcx run-length scanline decoder with a registered output stage
//
// Takes one encoded pcx byte per input transaction and expands it into decoded
// scanline bytes. A literal byte gives one output. A code byte (top two bits
// set) gives no output; the following value byte gives max(count,1) outputs,
// up to 63, one per cycle while m_tready keeps the output register free, and
// input is held off until the last of them has been loaded into the output
// register. All outputs of a run pass through the single row counter
// decrementer and the one output register. The row counter reloads from
// bytes_per_line at the first byte of each row; a run that passes the row end
// is emitted whole, and every output at or past the end carries row_end. No
// clearing pass follows reset.
module pcx_rle_row_decoder
    import pcx_rle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [14:0] cfg_data,    // bytes_per_line
    // encoded byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // in_byte
    // decoded byte stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,     // pixel
    output logic        m_tlast,     // last_of_run
    output logic        m_tuser      // row_end
);

    logic   state_reg, state_next;
    logic   awaiting_reg, awaiting_next;
    count_t run_count_reg, run_count_next;
    count_t remain_reg, remain_next;
    row_t   row_left_reg, row_left_next;
    line_t  bpl_reg;
    byte_t  pix_reg, pix_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_last_reg, out_last_next;
    logic   out_rowend_reg, out_rowend_next;

    logic   slot_free;
    logic   accept;
    logic   is_code;
    logic   reload;
    row_t   dec_base;
    row_t   dec_out;
    logic   dec_end;

    // handshake
    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && slot_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign is_code = ((s_tdata & CODE_MASK) == CODE_MASK);
    assign reload  = (state_reg == ST_IDLE) && !awaiting_reg && (row_left_reg <= 0);

    // shared row counter decrementer
    assign dec_base = reload ? row_t'({1'b0, bpl_reg}) : row_left_reg;
    assign dec_out  = dec_base - row_t'(1);
    assign dec_end  = dec_out[ROW_W-1] || (dec_out == '0);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        awaiting_next   = awaiting_reg;
        run_count_next  = run_count_reg;
        remain_next     = remain_reg;
        row_left_next   = row_left_reg;
        pix_next        = pix_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_last_next   = out_last_reg;
        out_rowend_next = out_rowend_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (!awaiting_reg && is_code)
                    begin
                        // code byte: keep count, reload row if due, no output
                        run_count_next = count_t'(s_tdata & COUNT_MASK);
                        awaiting_next  = 1'b1;
                        row_left_next  = dec_base;
                    end
                    else
                    begin
                        // literal or first byte of a run
                        row_left_next   = dec_out;
                        pix_next        = s_tdata;
                        out_valid_next  = 1'b1;
                        out_rowend_next = dec_end;
                        awaiting_next   = 1'b0;
                        if (awaiting_reg && (run_count_reg > count_t'(1)))
                        begin
                            out_last_next = 1'b0;
                            remain_next   = run_count_reg - count_t'(1);
                            state_next    = ST_RUN;
                        end
                        else
                        begin
                            out_last_next = 1'b1;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                // repeat the held value once per free output slot
                if (slot_free)
                begin
                    row_left_next   = dec_out;
                    out_valid_next  = 1'b1;
                    out_rowend_next = dec_end;
                    out_last_next   = (remain_reg == count_t'(1));
                    remain_next     = remain_reg - count_t'(1);
                    if (remain_reg == count_t'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            awaiting_reg  <= 1'b0;
            run_count_reg <= '0;
            remain_reg    <= '0;
            row_left_reg  <= '0;
            bpl_reg       <= LINE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            awaiting_reg  <= awaiting_next;
            run_count_reg <= run_count_next;
            remain_reg    <= remain_next;
            row_left_reg  <= row_left_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                bpl_reg <= cfg_data;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        pix_reg        <= pix_next;
        out_last_reg   <= out_last_next;
        out_rowend_reg <= out_rowend_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = pix_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_rowend_reg;

`ifndef SYNTHESIS
    // no input transaction while a run is being expanded
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> !s_tready)
        else $error("input accepted during run");

    // a run in progress always has outputs left
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (remain_reg != '0))
        else $error("run with zero remaining");

    // a code byte arms value mode and loads no output
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !awaiting_reg && is_code) |=> (awaiting_reg && (out_valid_reg ==
        ($past(out_valid_reg) && !$past(m_tready)))))
        else $error("code byte mishandled");

    // overshoot stays within one run
    assert property (@(posedge clk) disable iff (!rst_n)
        row_left_reg >= -row_t'(63))
        else $error("row counter overshoot too large");
`endif

endmodule

FILE: bench/tb.sv
// testbench for the pcx run-length row decoder: directed and random byte streams
`timescale 1ns / 1ps

module tb;
    import pcx_rle_pkg::*;

    localparam int    LIMIT_CYCLES = 400000;
    localparam int    PHASE_ITEMS  = 42;
    localparam byte_t LITERAL_MAX  = 8'hBF;
    localparam line_t LINE_MAX     = 15'h7FFF;
    localparam line_t LINE_ZERO    = 15'd0;
    localparam line_t LINE_ONE     = 15'd1;

    typedef struct packed {
        byte_t pixel;
        logic  last;
        logic  row_end;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [14:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // decoder state mirrored by the predictor
    line_t  line_len = LINE_RESET;
    logic   await_value = 1'b0;
    count_t run_len = '0;
    row_t   row_left = '0;

    byte_t  pending_bytes[$];
    pixel_t expected_pixels[$];

    int cycles = 0;
    int errors = 0;
    int in_count = 0;
    int out_count = 0;
    int row_ends = 0;
    int long_runs = 0;
    int cfg_writes = 0;
    int sender_idle;
    int recv_idle;

    pcx_rle_row_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // idle rates follow the input transaction count
    assign sender_idle = (in_count < 100) ? 19 : (in_count < 200) ? 72 : 0;
    assign recv_idle   = (in_count < 100) ? 72 : (in_count < 200) ? 19 : 0;

    // expand one accepted byte into the decoded pixels it should produce
    function automatic void expand_byte(input byte_t b);
        int     n;
        pixel_t p;
        if (!await_value)
        begin
            if (row_left <= 0)
                row_left = row_t'({1'b0, line_len});
            if ((b & CODE_MASK) == CODE_MASK)
            begin
                run_len = b[COUNT_W-1:0];
                await_value = 1'b1;
                return;
            end
            n = 1;
        end
        else
        begin
            await_value = 1'b0;
            n = (run_len > 1) ? int'(run_len) : 1;
            if (run_len > 1)
                long_runs++;
        end
        for (int k = 0; k < n; k++)
        begin
            row_left = row_left - 1;
            p.pixel = b;
            p.last = (k == n - 1);
            p.row_end = (row_left <= 0);
            expected_pixels.push_back(p);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < 20)
            $display("mismatch at output %0d: %s got %0h want %0h", out_count, what, got, want);
        errors++;
    endtask

    // encoded byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expand_byte(s_tdata);
                in_count <= in_count + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_bytes.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // decoded pixel monitor and receiver backpressure
    always @(posedge clk)
    begin : pixel_monitor
        pixel_t want;
        m_tready <= ($urandom_range(99) >= recv_idle);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
                report_mismatch("pixel with nothing expected", m_tdata, 0);
            else
            begin
                want = expected_pixels.pop_front();
                if (m_tdata !== want.pixel)
                    report_mismatch("pixel", m_tdata, want.pixel);
                if (m_tlast !== want.last)
                    report_mismatch("last_of_run", m_tlast, want.last);
                if (m_tuser !== want.row_end)
                    report_mismatch("row_end", m_tuser, want.row_end);
            end
            out_count <= out_count + 1;
            if (m_tuser === 1'b1)
                row_ends <= row_ends + 1;
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("pcx_rle_row_decoder verification failed");
            $finish;
        end
    end

    // wait until all queued bytes are taken and all pixels have come out
    task automatic wait_quiet();
        @(negedge clk);
        while (pending_bytes.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(negedge clk);
        // a trailing code byte gives no output, so let the block settle
        repeat (8) @(posedge clk);
    endtask

    // one transaction on the line length channel
    task automatic write_line_len(input line_t v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        line_len = v;
        cfg_writes++;
    endtask

    task automatic push_run(input int count, input byte_t value);
        pending_bytes.push_back(CODE_MASK | byte_t'(count));
        pending_bytes.push_back(value);
    endtask

    // mostly well formed runs and literals, some doubled code bytes
    task automatic fill_random(input int n);
        int r;
        int count;
        int pushed;
        pushed = 0;
        while (pushed < n)
        begin
            r = $urandom_range(99);
            if (r < 50)
            begin
                count = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(7);
                push_run(count, byte_t'($urandom_range(255)));
                pushed += 2;
            end
            else if (r < 92)
            begin
                pending_bytes.push_back(byte_t'($urandom_range(LITERAL_MAX)));
                pushed++;
            end
            else
            begin
                // code byte whose value byte also looks like a code
                push_run($urandom_range(63), CODE_MASK | byte_t'($urandom_range(63)));
                pushed += 2;
            end
        end
    endtask

    initial
    begin : stimulus
        line_t phase_len[6];

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: literal extremes, count zero and one, largest count
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(LITERAL_MAX);
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(8'h80);
        pending_bytes.push_back(8'h40);
        push_run(0, 8'hFF);
        push_run(1, 8'h00);
        push_run(2, 8'h55);
        push_run(63, CODE_MASK);
        push_run(5, 8'hAA);
        pending_bytes.push_back(8'h3F);
        push_run(63, 8'h01);
        wait_quiet();

        // line length sweep: shortest, zero, longest, then random and reset value
        phase_len[0] = LINE_ONE;
        phase_len[1] = LINE_ZERO;
        phase_len[2] = LINE_MAX;
        phase_len[3] = line_t'($urandom_range(2, 40));
        phase_len[4] = line_t'($urandom_range(41, 700));
        phase_len[5] = LINE_RESET;
        foreach (phase_len[i])
        begin
            write_line_len(phase_len[i]);
            if (i == 0)
                push_run(3, 8'h9C);
            fill_random(PHASE_ITEMS);
            wait_quiet();
        end

        repeat (16) @(posedge clk);
        $display("covered %0d encoded bytes, %0d pixels, %0d multi-byte runs, %0d row ends",
                 in_count, out_count, long_runs, row_ends);
        $display("across %0d line length writes including zero, one and the maximum",
                 cfg_writes);
        if (errors == 0)
            $display("pcx_rle_row_decoder verification clean");
        else
            $display("pcx_rle_row_decoder verification failed");
        $finish;
    end

endmodule
